/* rtl/core/pps_pkg.sv */
// Package for the process pick scheduler: command codes, controller states,
// control/status bundles, field widths and the mask lookup helper.
// No dependencies.
`default_nettype none

package pps_pkg;

    // Fixed field widths of the item and result ports
    localparam int unsigned PRI_W     = 8;
    localparam int unsigned MASK_W    = 16;
    localparam int unsigned CHOSEN_W  = 5;
    localparam int unsigned CUR_W     = 4;
    localparam int unsigned COUNT_W   = 5;
    localparam int unsigned TOTAL_W   = 20;
    localparam int unsigned MINW_W    = 17;
    localparam int unsigned MAXW_W    = 16;

    // Saturation limits of the reported statistics
    localparam logic [TOTAL_W-1:0] TOTAL_TOP = '1;
    localparam logic [MAXW_W-1:0]  STAT_TOP  = '1;
    localparam logic [MINW_W-1:0]  MIN_EMPTY = '1;
    localparam logic [CHOSEN_W-1:0] NONE_CHOSEN = '1;

    // Register map
    localparam int unsigned PADDR_W = 3;
    localparam logic REG_PRIORITY_MODE = 1'b0;

    typedef enum logic [1:0] {
        CMD_ADD  = 2'd0,
        CMD_PICK = 2'd1,
        CMD_TICK = 2'd2,
        CMD_NOP  = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_SCAN,
        S_DRAIN,
        S_FINISH
    } state_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic capture;
        logic decode;
        logic scan_rd;
        logic finish;
    } ctrl_t;

    // Status from datapath to controller
    typedef struct packed {
        logic table_empty;
        logic scan_last;
        logic out_free;
    } stat_t;

    // Mask bit lookup; entries at sixteen and above see zero
    function automatic logic mask_bit(logic [MASK_W-1:0] mask, logic [31:0] idx);
        logic bit_val;
        bit_val = 1'b0;
        if (idx < 32'(MASK_W))
        begin
            bit_val = mask[idx[3:0]];
        end
        return bit_val;
    endfunction

endpackage

`default_nettype wire

/* rtl/core/pps_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module pps_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

/* rtl/core/pps_ctrl.sv */
// Controller state machine for the process pick scheduler.
// Depends on pps_pkg; drives the datapath through ctrl_t, watches stat_t.
`default_nettype none

module pps_ctrl (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    output logic                in_ready,
    output pps_pkg::ctrl_t      ctrl,
    input  wire pps_pkg::stat_t stat
);

    import pps_pkg::*;

    state_t state_reg;
    state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        in_ready   = 1'b0;
        ctrl       = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    ctrl.capture = 1'b1;
                    state_next   = S_DECODE;
                end
            end
            S_DECODE:
            begin
                ctrl.decode = 1'b1;
                state_next  = stat.table_empty ? S_FINISH : S_SCAN;
            end
            S_SCAN:
            begin
                ctrl.scan_rd = 1'b1;
                if (stat.scan_last)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                if (stat.out_free)
                begin
                    ctrl.finish = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // An accepted transaction is always decoded next
    a_accept_decode: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg == S_DECODE))
        else $error("accepted transaction not decoded");

    // Finish only leaves through a free output register
    a_finish_free: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FINISH && !stat.out_free) |=> (state_reg == S_FINISH))
        else $error("finish left while output busy");

endmodule

`default_nettype wire

/* rtl/core/pps_datapath.sv */
// Datapath of the process pick scheduler: item capture, entry table RAM,
// one-entry-per-cycle scan for pick, tick and statistics, output register.
// Depends on pps_pkg and pps_ram.
`default_nettype none

module pps_datapath #(
    parameter int MAX_ENTRIES = 16,
    parameter int WAIT_WIDTH  = 16
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire pps_pkg::ctrl_t                    ctrl,
    output pps_pkg::stat_t                         stat,
    input  wire logic                              priority_mode,
    input  wire logic [1:0]                        command,
    input  wire logic [pps_pkg::PRI_W-1:0]         entry_priority,
    input  wire logic [pps_pkg::MASK_W-1:0]        ready_mask,
    input  wire logic [pps_pkg::MASK_W-1:0]        terminated_mask,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output logic signed [pps_pkg::CHOSEN_W-1:0]    chosen_index,
    output logic                                   switched,
    output logic [pps_pkg::CUR_W-1:0]              current_index,
    output logic [pps_pkg::COUNT_W-1:0]            entry_count,
    output logic                                   table_full,
    output logic [pps_pkg::TOTAL_W-1:0]            total_wait,
    output logic signed [pps_pkg::MINW_W-1:0]      min_wait,
    output logic [pps_pkg::MAXW_W-1:0]             max_wait,
    output logic                                   all_done
);

    import pps_pkg::*;

    localparam int IDX_W  = $clog2(MAX_ENTRIES);
    localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);
    localparam int ENT_W  = PRI_W + WAIT_WIDTH;
    localparam int SUM_W  = ((WAIT_WIDTH > TOTAL_W) ? WAIT_WIDTH : TOTAL_W) + 1;
    localparam int SAT_W  = (WAIT_WIDTH > MAXW_W) ? WAIT_WIDTH : MAXW_W;
    localparam logic [CNT_W-1:0] COUNT_MAX = CNT_W'(MAX_ENTRIES);

    // Captured item
    cmd_t              cmd_reg;
    logic [PRI_W-1:0]  pri_reg;
    logic [MASK_W-1:0] ready_reg;
    logic [MASK_W-1:0] term_reg;

    // Table control state
    logic [CNT_W-1:0]  count_reg,   count_next;
    logic [IDX_W-1:0]  cur_reg,     cur_next;
    logic [IDX_W-1:0]  idx_reg,     idx_next;
    logic [CNT_W-1:0]  rd_cnt_reg,  rd_cnt_next;
    logic              rd_pend_reg, rd_pend_next;
    logic [IDX_W-1:0]  idx_d_reg,   idx_d_next;
    logic              full_reg,    full_next;

    // Scan accumulators
    logic [TOTAL_W-1:0]    total_reg,  total_next;
    logic [WAIT_WIDTH-1:0] min_reg,    min_next;
    logic [WAIT_WIDTH-1:0] max_reg,    max_next;
    logic                  any_reg,    any_next;
    logic                  done_reg,   done_next;
    logic                  found_reg,  found_next;
    logic [PRI_W-1:0]      best_reg,   best_next;
    logic [IDX_W-1:0]      chosen_reg, chosen_next;

    // Output register
    logic                 out_valid_reg, out_valid_next;
    logic [CHOSEN_W-1:0]  o_chosen_reg,  o_chosen_next;
    logic                 o_switch_reg,  o_switch_next;
    logic [CUR_W-1:0]     o_cur_reg,     o_cur_next;
    logic [COUNT_W-1:0]   o_count_reg,   o_count_next;
    logic                 o_full_reg,    o_full_next;
    logic [TOTAL_W-1:0]   o_total_reg,   o_total_next;
    logic [MINW_W-1:0]    o_min_reg,     o_min_next;
    logic [MAXW_W-1:0]    o_max_reg,     o_max_next;
    logic                 o_done_reg,    o_done_next;

    // RAM ports
    logic             ram_we;
    logic [IDX_W-1:0] ram_waddr;
    logic [ENT_W-1:0] ram_wdata;
    logic [ENT_W-1:0] ram_rdata;

    // Entry evaluation
    logic [PRI_W-1:0]      e_pri;
    logic [WAIT_WIDTH-1:0] e_wait;
    logic [WAIT_WIDTH-1:0] e_wait_new;
    logic                  e_rdy;
    logic                  e_trm;
    logic                  e_inc;
    logic [SUM_W-1:0]      e_sum;
    logic                  do_add;
    logic                  do_switch;
    logic [SAT_W-1:0]      min_ext;
    logic [SAT_W-1:0]      max_ext;

    pps_ram #(
        .WIDTH (ENT_W),
        .DEPTH (MAX_ENTRIES)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (idx_reg),
        .rdata (ram_rdata)
    );

    // Status to controller
    always_comb
    begin
        stat.table_empty = (count_reg == '0) && (cmd_reg != CMD_ADD);
        stat.scan_last   = (rd_cnt_reg == count_reg - CNT_W'(1));
        stat.out_free    = !out_valid_reg || out_ready;
    end

    // Field split and per-entry decisions of the entry read last cycle
    always_comb
    begin
        e_pri      = ram_rdata[WAIT_WIDTH +: PRI_W];
        e_wait     = ram_rdata[WAIT_WIDTH-1:0];
        e_rdy      = mask_bit(ready_reg, 32'(idx_d_reg));
        e_trm      = mask_bit(term_reg, 32'(idx_d_reg));
        e_inc      = (cmd_reg == CMD_TICK) && (idx_d_reg != cur_reg) && !e_trm && e_rdy
                     && (e_wait != '1);
        e_wait_new = e_inc ? (e_wait + WAIT_WIDTH'(1)) : e_wait;
        e_sum      = SUM_W'(total_reg) + SUM_W'(e_wait_new);
        do_add     = (cmd_reg == CMD_ADD) && (count_reg != COUNT_MAX);
        do_switch  = (cmd_reg == CMD_PICK) && found_reg && (chosen_reg != cur_reg);
        min_ext    = SAT_W'(min_reg);
        max_ext    = SAT_W'(max_reg);
    end

    // RAM write: append on add, write back counter on tick
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = idx_d_reg;
        ram_wdata = {e_pri, e_wait_new};
        if (ctrl.decode && do_add)
        begin
            ram_we    = 1'b1;
            ram_waddr = IDX_W'(count_reg);
            ram_wdata = {pri_reg, {WAIT_WIDTH{1'b0}}};
        end
        else if (rd_pend_reg && e_inc)
        begin
            ram_we = 1'b1;
        end
    end

    // Next values of control state and accumulators
    always_comb
    begin
        count_next   = count_reg;
        cur_next     = cur_reg;
        idx_next     = idx_reg;
        rd_cnt_next  = rd_cnt_reg;
        rd_pend_next = 1'b0;
        idx_d_next   = idx_d_reg;
        full_next    = full_reg;
        total_next   = total_reg;
        min_next     = min_reg;
        max_next     = max_reg;
        any_next     = any_reg;
        done_next    = done_reg;
        found_next   = found_reg;
        best_next    = best_reg;
        chosen_next  = chosen_reg;

        // Decode: append entry, set up scan from the entry after current on a pick, else from entry 0
        if (ctrl.decode)
        begin
            full_next = (cmd_reg == CMD_ADD) && (count_reg == COUNT_MAX);
            if (do_add)
            begin
                count_next = count_reg + CNT_W'(1);
            end
            if (cmd_reg == CMD_PICK && (CNT_W'(cur_reg) + CNT_W'(1) != count_reg))
            begin
                idx_next = cur_reg + IDX_W'(1);
            end
            else
            begin
                idx_next = '0;
            end
            rd_cnt_next = '0;
            total_next  = '0;
            min_next    = '0;
            max_next    = '0;
            any_next    = 1'b0;
            done_next   = 1'b1;
            found_next  = 1'b0;
            best_next   = '0;
            chosen_next = '0;
        end

        // Scan: issue one read, step the wrapping index
        if (ctrl.scan_rd)
        begin
            rd_pend_next = 1'b1;
            idx_d_next   = idx_reg;
            rd_cnt_next  = rd_cnt_reg + CNT_W'(1);
            if (CNT_W'(idx_reg) + CNT_W'(1) == count_reg)
            begin
                idx_next = '0;
            end
            else
            begin
                idx_next = idx_reg + IDX_W'(1);
            end
        end

        // Evaluate: statistics, done flag and pick candidate
        if (rd_pend_reg)
        begin
            total_next = (e_sum > SUM_W'(TOTAL_TOP)) ? TOTAL_TOP : e_sum[TOTAL_W-1:0];
            if (!any_reg || e_wait_new < min_reg)
            begin
                min_next = e_wait_new;
            end
            if (e_wait_new > max_reg)
            begin
                max_next = e_wait_new;
            end
            any_next = 1'b1;
            if (!e_trm)
            begin
                done_next = 1'b0;
            end
            if (cmd_reg == CMD_PICK && e_rdy)
            begin
                if (!priority_mode)
                begin
                    if (!found_reg)
                    begin
                        found_next  = 1'b1;
                        chosen_next = idx_d_reg;
                    end
                end
                else if (e_pri >= best_reg)
                begin
                    found_next  = 1'b1;
                    best_next   = e_pri;
                    chosen_next = idx_d_reg;
                end
            end
        end

        // Finish: commit the switch
        if (ctrl.finish && do_switch)
        begin
            cur_next = chosen_reg;
        end
    end

    // Output register next values
    always_comb
    begin
        out_valid_next = out_valid_reg;
        o_chosen_next  = o_chosen_reg;
        o_switch_next  = o_switch_reg;
        o_cur_next     = o_cur_reg;
        o_count_next   = o_count_reg;
        o_full_next    = o_full_reg;
        o_total_next   = o_total_reg;
        o_min_next     = o_min_reg;
        o_max_next     = o_max_reg;
        o_done_next    = o_done_reg;
        if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (ctrl.finish)
        begin
            out_valid_next = 1'b1;
            o_chosen_next  = (cmd_reg == CMD_PICK && found_reg) ?
                             CHOSEN_W'(chosen_reg) : NONE_CHOSEN;
            o_switch_next  = do_switch;
            o_cur_next     = do_switch ? CUR_W'(chosen_reg) : CUR_W'(cur_reg);
            o_count_next   = COUNT_W'(count_reg);
            o_full_next    = full_reg;
            o_total_next   = total_reg;
            if (!any_reg)
            begin
                o_min_next = MIN_EMPTY;
            end
            else if (min_ext > SAT_W'(STAT_TOP))
            begin
                o_min_next = MINW_W'(STAT_TOP);
            end
            else
            begin
                o_min_next = MINW_W'(min_ext[MAXW_W-1:0]);
            end
            o_max_next  = (max_ext > SAT_W'(STAT_TOP)) ? STAT_TOP : max_ext[MAXW_W-1:0];
            o_done_next = done_reg;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            cur_reg       <= '0;
            rd_cnt_reg    <= '0;
            rd_pend_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            cur_reg       <= cur_next;
            rd_cnt_reg    <= rd_cnt_next;
            rd_pend_reg   <= rd_pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (ctrl.capture)
        begin
            cmd_reg   <= cmd_t'(command);
            pri_reg   <= entry_priority;
            ready_reg <= ready_mask;
            term_reg  <= terminated_mask;
        end
        idx_reg      <= idx_next;
        idx_d_reg    <= idx_d_next;
        full_reg     <= full_next;
        total_reg    <= total_next;
        min_reg      <= min_next;
        max_reg      <= max_next;
        any_reg      <= any_next;
        done_reg     <= done_next;
        found_reg    <= found_next;
        best_reg     <= best_next;
        chosen_reg   <= chosen_next;
        o_chosen_reg <= o_chosen_next;
        o_switch_reg <= o_switch_next;
        o_cur_reg    <= o_cur_next;
        o_count_reg  <= o_count_next;
        o_full_reg   <= o_full_next;
        o_total_reg  <= o_total_next;
        o_min_reg    <= o_min_next;
        o_max_reg    <= o_max_next;
        o_done_reg   <= o_done_next;
    end

    assign out_valid     = out_valid_reg;
    assign chosen_index  = o_chosen_reg;
    assign switched      = o_switch_reg;
    assign current_index = o_cur_reg;
    assign entry_count   = o_count_reg;
    assign table_full    = o_full_reg;
    assign total_wait    = o_total_reg;
    assign min_wait      = o_min_reg;
    assign max_wait      = o_max_reg;
    assign all_done      = o_done_reg;

    // The last read is evaluated before the result is loaded
    a_drained: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.finish |-> !rd_pend_reg)
        else $error("finish with a read still pending");

    // Table never overfills
    a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= COUNT_MAX)
        else $error("entry count above table size");

    // Current entry stays inside a non-empty table
    a_cur_range: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != '0) |-> (CNT_W'(cur_reg) < count_reg))
        else $error("current entry outside table");

endmodule

`default_nettype wire

/* rtl/core/process_pick_scheduler.sv */
// Top level of the process pick scheduler: configuration register, APB port,
// controller and datapath. Depends on pps_pkg, pps_ctrl, pps_datapath.
//
//   Channel   Handshake            Payload
//   in        in_valid / in_ready  command, entry_priority, ready_mask, terminated_mask
//   out       out_valid/out_ready  chosen_index .. all_done (9 fields)
//   cfg       APB psel/penable     priority_mode at byte address 0
//
// An item passes through decode, a scan with one table RAM read per entry of
// the table after the item, a drain step and finish before the next item is
// accepted. A pick, tick or no-op on an empty table skips the scan.
// The result is loaded in the finish step; the input stays ready while a
// previous result waits in the output register, and a new result waits in its
// finish step until that register is taken.
// Reset clears the table count, current entry and mode; no clearing pass runs.
`default_nettype none

module process_pick_scheduler #(
    parameter int MAX_ENTRIES = 16,
    parameter int WAIT_WIDTH  = 16
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    // APB configuration port
    input  wire logic                               psel,
    input  wire logic                               penable,
    input  wire logic                               pwrite,
    input  wire logic [pps_pkg::PADDR_W-1:0]        paddr,
    input  wire logic [31:0]                        pwdata,
    output logic      [31:0]                        prdata,
    output logic                                    pready,
    // Input transactions
    input  wire logic                               in_valid,
    output logic                                    in_ready,
    input  wire logic [1:0]                         command,
    input  wire logic [pps_pkg::PRI_W-1:0]          entry_priority,
    input  wire logic [pps_pkg::MASK_W-1:0]         ready_mask,
    input  wire logic [pps_pkg::MASK_W-1:0]         terminated_mask,
    // Result transactions
    output logic                                    out_valid,
    input  wire logic                               out_ready,
    output logic signed [pps_pkg::CHOSEN_W-1:0]     chosen_index,
    output logic                                    switched,
    output logic [pps_pkg::CUR_W-1:0]               current_index,
    output logic [pps_pkg::COUNT_W-1:0]             entry_count,
    output logic                                    table_full,
    output logic [pps_pkg::TOTAL_W-1:0]             total_wait,
    output logic signed [pps_pkg::MINW_W-1:0]       min_wait,
    output logic [pps_pkg::MAXW_W-1:0]              max_wait,
    output logic                                    all_done
);

    import pps_pkg::*;

    logic  mode_reg;
    logic  mode_next;
    logic  cfg_wr;
    ctrl_t ctrl;
    stat_t stat;

    // Configuration register write
    always_comb
    begin
        pready    = 1'b1;
        cfg_wr    = psel && penable && pwrite;
        mode_next = mode_reg;
        if (cfg_wr && paddr[2] == REG_PRIORITY_MODE)
        begin
            mode_next = pwdata[0];
        end
    end

    // Register readback
    always_comb
    begin
        prdata = '0;
        if (paddr[2] == REG_PRIORITY_MODE)
        begin
            prdata = {31'b0, mode_reg};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= 1'b0;
        end
        else
        begin
            mode_reg <= mode_next;
        end
    end

    pps_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .ctrl     (ctrl),
        .stat     (stat)
    );

    pps_datapath #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .WAIT_WIDTH  (WAIT_WIDTH)
    ) u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .ctrl            (ctrl),
        .stat            (stat),
        .priority_mode   (mode_reg),
        .command         (command),
        .entry_priority  (entry_priority),
        .ready_mask      (ready_mask),
        .terminated_mask (terminated_mask),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .chosen_index    (chosen_index),
        .switched        (switched),
        .current_index   (current_index),
        .entry_count     (entry_count),
        .table_full      (table_full),
        .total_wait      (total_wait),
        .min_wait        (min_wait),
        .max_wait        (max_wait),
        .all_done        (all_done)
    );

endmodule

`default_nettype wire

/* sim/testbench.sv */
// Self-checking testbench for process_pick_scheduler: drives add, pick, tick and no-op
// transactions, predicts every report in place and compares it field by field.
// Depends on pps_pkg and the process_pick_scheduler RTL.
`default_nettype none

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import pps_pkg::*;

    localparam int          MAX_ENTRIES = 16;
    localparam logic [15:0] WAIT_SAT    = 16'hFFFF;
    localparam int          TICK_RUN    = 140;
    localparam int          CYCLE_LIMIT = 3_000_000;

    // One report as the block presents it; signed fields kept as raw bits
    typedef struct packed {
        logic [4:0]  chosen;
        logic        switched;
        logic [3:0]  current;
        logic [4:0]  count;
        logic        full;
        logic [19:0] total;
        logic [16:0] min_w;
        logic [15:0] max_w;
        logic        done;
    } sched_report_t;

    // DUT connections, all inputs known from time zero
    logic                       clk             = 1'b0;
    logic                       rst_n           = 1'b0;
    logic                       psel            = 1'b0;
    logic                       penable         = 1'b0;
    logic                       pwrite          = 1'b0;
    logic [PADDR_W-1:0]         paddr           = '0;
    logic [31:0]                pwdata          = '0;
    logic [31:0]                prdata;
    logic                       pready;
    logic                       in_valid        = 1'b0;
    logic                       in_ready;
    logic [1:0]                 command         = CMD_NOP;
    logic [PRI_W-1:0]           entry_priority  = '0;
    logic [MASK_W-1:0]          ready_mask      = '0;
    logic [MASK_W-1:0]          terminated_mask = '0;
    logic                       out_valid;
    logic                       out_ready       = 1'b0;
    logic signed [CHOSEN_W-1:0] chosen_index;
    logic                       switched;
    logic [CUR_W-1:0]           current_index;
    logic [COUNT_W-1:0]         entry_count;
    logic                       table_full;
    logic [TOTAL_W-1:0]         total_wait;
    logic signed [MINW_W-1:0]   min_wait;
    logic [MAXW_W-1:0]          max_wait;
    logic                       all_done;

    // Scheduler shadow state
    logic [7:0]  prio_table [MAX_ENTRIES];
    logic [15:0] wait_table [MAX_ENTRIES];
    int          table_size       = 0;
    int          current_slot     = 0;
    bit          pick_by_priority = 1'b0;

    sched_report_t pending_reports[$];
    bit            gaps_on       = 1'b1;
    int            error_count   = 0;
    int            sent_count    = 0;
    int            checked_count = 0;
    int            mode_writes   = 0;
    int            refused_adds  = 0;
    int            cycle_count   = 0;

    process_pick_scheduler uut (
        .clk             (clk),
        .rst_n           (rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .command         (command),
        .entry_priority  (entry_priority),
        .ready_mask      (ready_mask),
        .terminated_mask (terminated_mask),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .chosen_index    (chosen_index),
        .switched        (switched),
        .current_index   (current_index),
        .entry_count     (entry_count),
        .table_full      (table_full),
        .total_wait      (total_wait),
        .min_wait        (min_wait),
        .max_wait        (max_wait),
        .all_done        (all_done)
    );

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d reports outstanding",
                     cycle_count, pending_reports.size());
            $display("TEST FAILED");
            $finish;
        end
    end

    // Compare one field; only the first ten mismatches are printed
    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            error_count++;
            if (error_count <= 10)
                $display("mismatch on %s, report %0d: expected 0x%0h, got 0x%0h",
                         name, checked_count, want, got);
        end
    endtask

    // Apply one transaction to the shadow state and build the report it causes
    task automatic predict_schedule(input cmd_t cmd, input logic [7:0] pri,
                                    input logic [15:0] rdy, input logic [15:0] term,
                                    output sched_report_t rep);
        int pick;
        int top_pri;
        int slot;
        int sum;
        int lo;
        int hi;
        bit found;
        bit everyone_done;
        pick = -1;
        top_pri = 0;
        found = 1'b0;
        sum = 0;
        lo = 0;
        hi = 0;
        everyone_done = 1'b1;
        rep = '0;
        case (cmd)
            CMD_ADD:
            begin
                if (table_size >= MAX_ENTRIES)
                begin
                    rep.full = 1'b1;
                    refused_adds++;
                end
                else
                begin
                    prio_table[table_size] = pri;
                    wait_table[table_size] = '0;
                    table_size++;
                end
            end
            CMD_PICK:
            begin
                // scan starts after the current entry and ends on it
                for (int k = 1; k <= table_size; k++)
                begin
                    slot = (current_slot + k) % table_size;
                    if (rdy[slot] && !found)
                    begin
                        if (!pick_by_priority)
                        begin
                            pick = slot;
                            found = 1'b1;
                        end
                        else if (int'(prio_table[slot]) >= top_pri)
                        begin
                            // later entries win ties
                            top_pri = int'(prio_table[slot]);
                            pick = slot;
                        end
                    end
                end
                if (pick >= 0 && pick != current_slot)
                begin
                    current_slot = pick;
                    rep.switched = 1'b1;
                end
            end
            CMD_TICK:
            begin
                for (int i = 0; i < table_size; i++)
                begin
                    if (i != current_slot && !term[i] && rdy[i] && wait_table[i] != WAIT_SAT)
                        wait_table[i]++;
                end
            end
            default:
            begin
            end
        endcase
        // statistics over valid entries; 16 saturated counters still fit total_wait
        for (int i = 0; i < table_size; i++)
        begin
            sum += int'(wait_table[i]);
            if (i == 0 || int'(wait_table[i]) < lo)
                lo = int'(wait_table[i]);
            if (int'(wait_table[i]) > hi)
                hi = int'(wait_table[i]);
            if (!term[i])
                everyone_done = 1'b0;
        end
        rep.chosen  = 5'(pick);
        rep.current = 4'(current_slot);
        rep.count   = 5'(table_size);
        rep.total   = 20'(sum);
        rep.min_w   = (table_size == 0) ? '1 : 17'(lo);
        rep.max_w   = 16'(hi);
        rep.done    = everyone_done;
    endtask

    // Present one transaction and record its expected report on acceptance
    task automatic send_item(input cmd_t cmd, input logic [7:0] pri,
                             input logic [15:0] rdy, input logic [15:0] term);
        sched_report_t want;
        @(negedge clk);
        while (gaps_on && $urandom_range(99) < 10)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid        = 1'b1;
        command         = cmd;
        entry_priority  = pri;
        ready_mask      = rdy;
        terminated_mask = term;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predict_schedule(cmd, pri, rdy, term, want);
        pending_reports.push_back(want);
        sent_count++;
    endtask

    // Drop valid after the last accepted transaction
    task automatic stop_sending();
        @(negedge clk);
        in_valid = 1'b0;
    endtask

    // Write the mode register while idle, then read it back
    task automatic set_priority_mode(input bit mode);
        stop_sending();
        while (pending_reports.size() != 0)
            @(posedge clk);
        repeat (MAX_ENTRIES + 4) @(posedge clk);
        @(negedge clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = PADDR_W'(4 * int'(REG_PRIORITY_MODE));
        pwdata  = 32'(mode);
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        pick_by_priority = mode;
        mode_writes++;
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        // read back
        @(negedge clk);
        psel = 1'b1;
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        check_field("prdata", 32'(pick_by_priority), prdata);
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    function automatic logic [15:0] random_mask();
        logic [15:0] m;
        case ($urandom_range(9))
            0: m = 16'h0000;
            1: m = 16'hFFFF;
            2: m = 16'h0001 << $urandom_range(15);
            default: m = 16'($urandom());
        endcase
        return m;
    endfunction

    // Result sink: random stalls at the falling edge
    always @(negedge clk)
        out_ready = gaps_on ? ($urandom_range(99) >= 10) : 1'b1;

    // Report checker
    always @(posedge clk)
    begin
        sched_report_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_reports.size() == 0)
            begin
                error_count++;
                if (error_count <= 10)
                    $display("report with no transaction outstanding");
            end
            else
            begin
                want = pending_reports.pop_front();
                check_field("chosen_index", want.chosen, $unsigned(chosen_index));
                check_field("switched", want.switched, switched);
                check_field("current_index", want.current, current_index);
                check_field("entry_count", want.count, entry_count);
                check_field("table_full", want.full, table_full);
                check_field("total_wait", want.total, total_wait);
                check_field("min_wait", want.min_w, $unsigned(min_wait));
                check_field("max_wait", want.max_w, max_wait);
                check_field("all_done", want.done, all_done);
                checked_count++;
            end
        end
    end

    // Empty table: pick finds nothing, tick changes nothing, all_done reads 1
    task automatic test_empty_table();
        set_priority_mode(1'b0);
        send_item(CMD_PICK, 8'h00, 16'hFFFF, 16'h0000);
        send_item(CMD_PICK, 8'hFF, 16'h0000, 16'hFFFF);
        send_item(CMD_TICK, 8'h00, 16'hFFFF, 16'h0000);
        send_item(CMD_NOP, 8'hFF, 16'hFFFF, 16'hFFFF);
    endtask

    // Two entries; a long run of ticks on the non-current one, mostly gap-free
    task automatic test_wait_counting();
        send_item(CMD_ADD, 8'hFF, 16'h0000, 16'hFFFF);
        send_item(CMD_ADD, 8'h00, 16'hFFFF, 16'h0000);
        for (int i = 0; i < TICK_RUN; i++)
        begin
            gaps_on = (i < 40);
            send_item(CMD_TICK, 8'($urandom()), 16'($urandom()) | 16'h0002,
                      16'($urandom()) & ~16'h0002);
        end
        gaps_on = 1'b1;
        // pick of the current entry keeps it, then move to the counting one
        send_item(CMD_PICK, 8'h00, 16'h0001, 16'h0000);
        send_item(CMD_PICK, 8'h00, 16'h0002, 16'h0000);
        send_item(CMD_TICK, 8'h00, 16'hFFFF, 16'h0000);
        send_item(CMD_TICK, 8'h00, 16'hFFFF, 16'h0001);
    endtask

    // Grow to a full table with picks and ticks on the way, then overfill
    task automatic test_fill_table();
        logic [7:0] prios [14] = '{8'h80, 8'h01, 8'hFE, 8'hFF, 8'h80, 8'h55, 8'hAA,
                                   8'h00, 8'h80, 8'h7F, 8'hFF, 8'h10, 8'h80, 8'h01};
        set_priority_mode(1'b1);
        for (int i = 0; i < 14; i++)
        begin
            if (i == 7)
                set_priority_mode(1'b0);
            send_item(CMD_ADD, prios[i], random_mask(), random_mask());
            send_item(CMD_PICK, 8'($urandom()), random_mask(), random_mask());
            send_item(CMD_TICK, 8'($urandom()), random_mask(), random_mask());
        end
        send_item(CMD_ADD, 8'hFF, 16'hFFFF, 16'h0000);
        send_item(CMD_ADD, 8'h00, 16'h0000, 16'hFFFF);
        send_item(CMD_NOP, 8'h00, 16'h0000, 16'hFFFF);
        send_item(CMD_NOP, 8'h00, 16'h0000, 16'h7FFF);
    endtask

    // Both pick policies on a full table: ties, nothing ready, only current ready
    task automatic test_pick_modes();
        set_priority_mode(1'b1);
        send_item(CMD_PICK, 8'h00, 16'hFFFF, 16'h0000);
        send_item(CMD_PICK, 8'h00, 16'h0000, 16'h0000);
        send_item(CMD_PICK, 8'h00, 16'h0001 << current_slot, 16'h0000);
        send_item(CMD_PICK, 8'h00, 16'h0881, 16'h0000);
        set_priority_mode(1'b0);
        send_item(CMD_PICK, 8'h00, 16'hFFFF, 16'h0000);
        send_item(CMD_PICK, 8'h00, 16'h0000, 16'hFFFF);
        send_item(CMD_PICK, 8'h00, 16'h0001 << current_slot, 16'h0000);
        send_item(CMD_PICK, 8'h00, 16'h8000, 16'h0000);
    endtask

    // Random command mix in phases, mode changed between phases
    task automatic test_random_traffic();
        bit phase_mode [5] = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1};
        int roll;
        cmd_t cmd;
        for (int p = 0; p < 5; p++)
        begin
            set_priority_mode(phase_mode[p]);
            gaps_on = (p != 2);
            for (int i = 0; i < 60; i++)
            begin
                roll = $urandom_range(99);
                if (roll < 5)
                    cmd = CMD_ADD;
                else if (roll < 40)
                    cmd = CMD_PICK;
                else if (roll < 85)
                    cmd = CMD_TICK;
                else
                    cmd = CMD_NOP;
                send_item(cmd, 8'($urandom()), random_mask(), random_mask());
            end
        end
        gaps_on = 1'b1;
    endtask

    initial
    begin
        repeat (7) @(negedge clk);
        rst_n = 1'b1;

        test_empty_table();
        test_wait_counting();
        test_fill_table();
        test_pick_modes();
        test_random_traffic();

        // drain outstanding reports, then watch for strays
        stop_sending();
        while (pending_reports.size() != 0)
            @(posedge clk);
        repeat (MAX_ENTRIES + 8) @(posedge clk);

        $display("%0d transactions sent, %0d reports checked, %0d mode writes, %0d adds refused",
                 sent_count, checked_count, mode_writes, refused_adds);
        $display("covered empty table, wait counting, full table, both pick policies");
        if (error_count == 0)
        begin
            $display("TEST PASSED");
        end
        else
        begin
            $display("%0d mismatches", error_count);
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire
